@@ sv/length_appended_crc32_checksum_core_assert.svh @@
// assertion macros for the checksum core
`ifndef LENGTH_APPENDED_CRC32_CHECKSUM_CORE_ASSERT_SVH
`define LENGTH_APPENDED_CRC32_CHECKSUM_CORE_ASSERT_SVH

// same-cycle implication
`define LACC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lacc assertion failed");

// next-cycle implication
`define LACC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lacc assertion failed");

`endif

@@ sv/lacc_pkg.sv @@
`default_nettype none
package lacc_pkg;

  localparam logic [31:0] POLY_REFLECTED = 32'hEDB88320;

  typedef struct packed {
    logic beat;
    logic fold_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fold_done;
  } stat_t;

  function automatic logic [31:0] crc_table(input logic [7:0] idx);
    logic [31:0] v;
    v = {24'h0, idx};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ POLY_REFLECTED;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    return {crc[23:0], 8'h00} ^ crc_table(crc[31:24] ^ b);
  endfunction

endpackage
`default_nettype wire

@@ sv/lacc_in_if.sv @@
`default_nettype none
interface lacc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       stream_end;

  modport source (output valid, output data_byte, output byte_present, output stream_end,
                  input ready);
  modport sink (input valid, input data_byte, input byte_present, input stream_end,
                output ready);
endinterface
`default_nettype wire

@@ sv/lacc_out_if.sv @@
`default_nettype none
interface lacc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;
  logic        count_overflow;

  modport source (output valid, output checksum, output count_overflow, input ready);
  modport sink (input valid, input checksum, input count_overflow, output ready);
endinterface
`default_nettype wire

@@ sv/lacc_ctrl.sv @@
`default_nettype none
module lacc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          stream_end,
  input  wire logic          out_ready,
  input  wire lacc_pkg::stat_t stat,
  output logic               in_ready,
  output logic               out_valid,
  output lacc_pkg::cmd_t     cmd
);

  localparam logic S_RUN  = 1'b0;
  localparam logic S_FOLD = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic slot_free;

  assign in_ready  = (state == S_RUN);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    case (state)
      S_RUN: begin
        cmd.beat = in_valid;
        if (in_valid && stream_end) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        if (stat.fold_done) begin
          if (slot_free) begin
            cmd.finish = 1'b1;
            state_next = S_RUN;
          end
        end else begin
          cmd.fold_step = 1'b1;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/lacc_dpath.sv @@
`default_nettype none
module lacc_dpath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lacc_pkg::cmd_t cmd,
  input  wire logic [7:0]     data_byte,
  input  wire logic           byte_present,
  input  wire logic           stream_end,
  output lacc_pkg::stat_t     stat,
  output logic [31:0]         checksum,
  output logic                count_overflow
);

  logic [31:0] crc;
  logic [31:0] count;
  logic        ovf;
  logic [31:0] len;

  logic [31:0] crc_next;
  logic [31:0] count_next;
  logic        ovf_next;
  logic [31:0] count_inc;
  logic        count_full;
  logic        take;
  logic [7:0]  feed_byte;
  logic [31:0] feed_out;

  assign count_inc  = count + 32'd1;
  assign count_full = (count == 32'hFFFF_FFFF);
  assign take       = cmd.beat && byte_present && !ovf;

  // one shared table step for stream bytes and length bytes
  assign feed_byte = cmd.fold_step ? len[7:0] : data_byte;
  assign feed_out  = lacc_pkg::crc_feed(crc, feed_byte);

  assign stat.fold_done = ovf || (len == 32'h0);

  always_comb begin
    crc_next   = crc;
    count_next = count;
    ovf_next   = ovf;
    if (cmd.finish) begin
      crc_next   = 32'h0;
      count_next = 32'h0;
      ovf_next   = 1'b0;
    end else if (cmd.fold_step) begin
      crc_next = feed_out;
    end else if (take) begin
      if (count_full) begin
        ovf_next = 1'b1;
      end else begin
        count_next = count_inc;
        crc_next   = feed_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= 32'h0;
      count <= 32'h0;
      ovf   <= 1'b0;
    end else begin
      crc   <= crc_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.beat && stream_end) begin
      len <= count_next;
    end else if (cmd.fold_step) begin
      len <= len >> 8;
    end
    if (cmd.finish) begin
      checksum       <= ovf ? 32'h0 : ~crc;
      count_overflow <= ovf;
    end
  end

endmodule
`default_nettype wire

@@ sv/length_appended_crc32_checksum_core.sv @@
// length-appended crc-32 checksum core
//
// in_ch carries one beat per item: data_byte, byte_present, stream_end.
// a beat with byte_present folds data_byte into the running crc and counts
// it; a beat with stream_end closes the stream. out_ch carries one beat per
// stream: the inverted length-appended checksum and count_overflow.
//
// stream bytes are taken at one beat per cycle through a single table step
// while in_ch.ready is high. after the end beat, in_ch.ready drops while
// the nonzero-led bytes of the byte count are folded, one per cycle through
// the same table step; then the output register is loaded once the output
// slot is free.
//
// the output register holds the result while out_ch.ready is low; bytes
// of the next stream keep flowing, and only its end waits for the slot.
// on overflow of the 32-bit count the checksum is zero and count_overflow
// is set. rst (synchronous) clears crc, count, overflow flag and out valid.
`default_nettype none
`include "length_appended_crc32_checksum_core_assert.svh"
module length_appended_crc32_checksum_core (
  input wire logic   clk,
  input wire logic   rst,
  lacc_in_if.sink    in_ch,
  lacc_out_if.source out_ch
);

  lacc_pkg::cmd_t  cmd;
  lacc_pkg::stat_t stat;
  logic            in_ready;
  logic            out_valid;

  lacc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .stream_end (in_ch.stream_end),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  lacc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .data_byte      (in_ch.data_byte),
    .byte_present   (in_ch.byte_present),
    .stream_end     (in_ch.stream_end),
    .stat           (stat),
    .checksum       (out_ch.checksum),
    .count_overflow (out_ch.count_overflow)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  `LACC_ASSERT_NOW(a_ovf_zero, clk, rst, out_ch.valid && out_ch.count_overflow, out_ch.checksum == 32'h0)
  `LACC_ASSERT_NEXT(a_end_stalls, clk, rst, in_ch.valid && in_ch.ready && in_ch.stream_end, !in_ch.ready)
  `LACC_ASSERT_NOW(a_load_from_fold, clk, rst, $rose(out_ch.valid), $past(!in_ch.ready))
  `LACC_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.beat, cmd.fold_step, cmd.finish}))

endmodule
`default_nettype wire
